// ===== hdl/cmmr_pkg.sv =====
// Shared types, constants and tables of the circle-map orbit multiplier core.
// No dependencies.
package cmmr_pkg;

    localparam int MAX_PERIOD = 16;
    localparam int PW = $clog2(MAX_PERIOD);

    localparam logic [4:0]  PERIOD_RST = 5'd2;
    localparam logic [31:0] THR_RST    = 32'd10737;
    localparam logic [47:0] TARGET_RST = 48'hFFFF_FF00_0000;

    localparam logic [30:0] ONE30      = 31'h4000_0000;
    localparam logic signed [29:0] ONE24 = 30'sh100_0000;
    localparam logic signed [31:0] INV2PI_Q32 = 32'sd683565276;
    localparam logic [54:0] PROD_MAX   = 55'h7FFF_FFFF_FFFF;
    localparam logic [54:0] PROD_MIN_MAG = 55'h8000_0000_0000;

    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_THR    = 2'd1,
        REG_TARGET = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SETX, S_SQ, S_HORN, S_FIN, S_KCOS,
        S_MULH, S_MULL, S_KSIN, S_INV, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SETX, OP_SQ, OP_HORN, OP_FIN_A, OP_FIN_B,
        OP_KCOS, OP_MULH, OP_MULL, OP_KSIN, OP_INV, OP_DONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] coef_idx;
    } cmd_t;

    typedef struct packed {
        logic          thr_fail;
        logic [PW-1:0] p_last;
        logic          out_blocked;
    } status_t;

    // Horner coefficients of the quarter sine, from C11 down to C1
    function automatic logic [30:0] horner_coef(input logic [2:0] idx);
        logic [30:0] c;
        unique case (idx)
            3'd0:    c = 31'd3864;
            3'd1:    c = 31'd172272;
            3'd2:    c = 31'd5026995;
            3'd3:    c = 31'd85569305;
            3'd4:    c = 31'd693598668;
            3'd5:    c = 31'd1686629713;
            default: c = 31'd0;
        endcase
        return c;
    endfunction

    localparam logic [30:0] C13 = 31'd61;
    localparam logic [2:0]  HORN_LAST = 3'd5;

endpackage

// ===== hdl/circle_map_multiplier_residual_core.sv =====
// A rejected point goes straight from the check to the output register; an accepted one walks
// the orbit. Items enter only in idle; the shared multiplier does one product per cycle.
// The output register lets the next item enter while a result waits.
// Reset (aresetn low, synchronous) empties the block and restores register defaults.
// Top level; depends on cmmr_pkg, cmmr_ctrl, cmmr_datapath.
module circle_map_multiplier_residual_core import cmmr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // start_point, omega, k_gain, pp_value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // deviation
    output logic         m_axis_tuser   // not_periodic
);

    cmd_t    cmd;
    status_t status;

    cmmr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    cmmr_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== hdl/cmmr_ctrl.sv =====
// Sequencer of the orbit walk: issues one datapath command per cycle.
// Depends on cmmr_pkg.
module cmmr_ctrl import cmmr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t        state_reg, state_next;
    logic [2:0]    hcnt_reg, hcnt_next;
    logic          phase_reg, phase_next;
    logic [PW-1:0] pt_reg, pt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            hcnt_reg  <= '0;
            phase_reg <= 1'b0;
            pt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            hcnt_reg  <= hcnt_next;
            phase_reg <= phase_next;
            pt_reg    <= pt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        hcnt_next  = hcnt_reg;
        phase_next = phase_reg;
        pt_next    = pt_reg;
        unique case (state_reg)
            S_IDLE: begin
                pt_next = '0;
                if (s_axis_tvalid) state_next = S_CHECK;
            end
            S_CHECK: state_next = status.thr_fail ? S_DONE : S_SETX;
            S_SETX: begin
                phase_next = 1'b0;
                state_next = S_SQ;
            end
            S_SQ: begin
                hcnt_next  = '0;
                state_next = S_HORN;
            end
            S_HORN: begin
                hcnt_next = hcnt_reg + 3'd1;
                if (hcnt_reg == HORN_LAST) state_next = S_FIN;
            end
            S_FIN: begin
                phase_next = 1'b1;
                state_next = phase_reg ? S_KCOS : S_SQ;
            end
            S_KCOS: state_next = S_MULH;
            S_MULH: state_next = S_MULL;
            S_MULL: state_next = (pt_reg == status.p_last) ? S_DONE : S_KSIN;
            S_KSIN: state_next = S_INV;
            S_INV: begin
                pt_next    = pt_reg + 1'b1;
                state_next = S_SETX;
            end
            S_DONE: if (!status.out_blocked) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op       = OP_NONE;
        cmd.coef_idx = hcnt_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) cmd.op = OP_LOAD;
            end
            S_CHECK: cmd.op = OP_NONE;
            S_SETX:  cmd.op = OP_SETX;
            S_SQ:    cmd.op = OP_SQ;
            S_HORN:  cmd.op = OP_HORN;
            S_FIN:   cmd.op = phase_reg ? OP_FIN_B : OP_FIN_A;
            S_KCOS:  cmd.op = OP_KCOS;
            S_MULH:  cmd.op = OP_MULH;
            S_MULL:  cmd.op = OP_MULL;
            S_KSIN:  cmd.op = OP_KSIN;
            S_INV:   cmd.op = OP_INV;
            S_DONE:  if (!status.out_blocked) cmd.op = OP_DONE;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== hdl/cmmr_datapath.sv =====
// Datapath: config registers, one shared multiplier, orbit and product registers,
// output register. Depends on cmmr_pkg.
module cmmr_datapath import cmmr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    input  logic [127:0] s_axis_tdata,
    input  cmd_t         cmd,
    output status_t      status,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,
    output logic         m_axis_tuser
);

    logic [4:0]         period_reg;
    logic [31:0]        thr_reg;
    logic signed [47:0] target_reg;

    logic signed [31:0] z_reg, z_next, om_reg, om_next, k_reg, k_next;
    logic               fail_reg, fail_next;
    logic [1:0]         quad_reg, quad_next;
    logic [30:0]        x_reg, x_next, arg_reg, arg_next, s_reg, s_next;
    logic [30:0]        t_reg, t_next, a_reg, a_next;
    logic signed [31:0] sn_reg, sn_next, cs_reg, cs_next;
    logic signed [47:0] prod_reg, prod_next;
    logic [47:0]        ua_reg, ua_next;
    logic [29:0]        ub_reg, ub_next;
    logic               neg_reg, neg_next;
    logic [54:0]        mh_reg, mh_next;
    logic signed [35:0] t1_reg, t1_next;
    logic               ov_reg;
    logic [47:0]        dev_reg;
    logic               np_reg;

    logic signed [35:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [67:0] mul_p;

    logic [30:0]        poly;
    logic signed [31:0] pa, pb;
    logic signed [29:0] factor;
    logic [54:0]        mag;
    logic signed [35:0] t2;
    logic signed [36:0] w, wn;
    logic signed [48:0] diff;
    logic [47:0]        dev;
    logic [4:0]         pclamp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RST;
            thr_reg    <= THR_RST;
            target_reg <= TARGET_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PERIOD: period_reg <= cfg_wdata[4:0];
                REG_THR:    thr_reg    <= cfg_wdata[31:0];
                REG_TARGET: target_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (period_reg == 5'd0) pclamp = 5'd1;
        else if (period_reg > 5'(MAX_PERIOD)) pclamp = 5'(MAX_PERIOD);
        else pclamp = period_reg;
    end

    assign status.thr_fail    = fail_reg;
    assign status.p_last      = PW'(pclamp - 5'd1);
    assign status.out_blocked = ov_reg && !m_axis_tready;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQ: begin
                mul_a = 36'(arg_reg);
                mul_b = 32'(arg_reg);
            end
            OP_HORN: begin
                mul_a = 36'(s_reg);
                mul_b = 32'(t_reg);
            end
            OP_FIN_A, OP_FIN_B: begin
                mul_a = 36'(arg_reg);
                mul_b = 32'(t_reg);
            end
            OP_KCOS: begin
                mul_a = 36'(k_reg);
                mul_b = cs_reg;
            end
            OP_MULH: begin
                mul_a = 36'(ua_reg[47:24]);
                mul_b = 32'(ub_reg);
            end
            OP_MULL: begin
                mul_a = 36'(ua_reg[23:0]);
                mul_b = 32'(ub_reg);
            end
            OP_KSIN: begin
                mul_a = 36'(k_reg);
                mul_b = sn_reg;
            end
            OP_INV: begin
                mul_a = t1_reg;
                mul_b = INV2PI_Q32;
            end
            default: ;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign poly   = mul_p[60:30];
    assign factor = ONE24 - 30'(mul_p >>> 34);
    assign mag    = mh_reg + 55'(mul_p[54:24]);
    assign t2     = 36'(mul_p >>> 32);
    assign w      = 37'(z_reg) + 37'(om_reg) - 37'(t2);
    assign wn     = -w;
    assign diff   = 49'(prod_reg) - 49'(target_reg);
    assign dev    = diff[48] ? 48'(-diff) : diff[47:0];

    // quadrant fold of sin/cos from a = S(x), b = S(1-x)
    always_comb begin
        unique case (quad_reg)
            2'd0: begin pa = 32'(a_reg);  pb = 32'(poly);  end
            2'd1: begin pa = 32'(poly);   pb = -32'(a_reg); end
            2'd2: begin pa = -32'(a_reg); pb = -32'(poly); end
            default: begin pa = -32'(poly); pb = 32'(a_reg); end
        endcase
    end

    always_comb begin
        z_next = z_reg;   om_next = om_reg;  k_next = k_reg;
        fail_next = fail_reg; quad_next = quad_reg; x_next = x_reg;
        arg_next = arg_reg; s_next = s_reg; t_next = t_reg; a_next = a_reg;
        sn_next = sn_reg; cs_next = cs_reg; prod_next = prod_reg;
        ua_next = ua_reg; ub_next = ub_reg; neg_next = neg_reg;
        mh_next = mh_reg; t1_next = t1_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                z_next    = s_axis_tdata[31:0];
                om_next   = s_axis_tdata[63:32];
                k_next    = s_axis_tdata[95:64];
                fail_next = s_axis_tdata[127:96] >= thr_reg;
                prod_next = 48'(ONE24);
            end
            OP_SETX: begin
                quad_next = z_reg[29:28];
                x_next    = {1'b0, z_reg[27:0], 2'b00};
                arg_next  = {1'b0, z_reg[27:0], 2'b00};
            end
            OP_SQ: begin
                s_next = poly;
                t_next = C13;
            end
            OP_HORN: t_next = horner_coef(cmd.coef_idx) - poly;
            OP_FIN_A: begin
                a_next   = poly;
                arg_next = ONE30 - x_reg;
            end
            OP_FIN_B: begin
                sn_next = pa;
                cs_next = pb;
            end
            OP_KCOS: begin
                ua_next  = prod_reg[47] ? 48'(-prod_reg) : 48'(prod_reg);
                ub_next  = factor[29] ? 30'(-factor) : 30'(factor);
                neg_next = prod_reg[47] != factor[29];
            end
            OP_MULH: mh_next = mul_p[54:0];
            OP_MULL: begin
                if (neg_reg) begin
                    prod_next = (mag >= PROD_MIN_MAG) ? 48'sh8000_0000_0000
                                                      : -48'(mag);
                end else begin
                    prod_next = (mag > PROD_MAX) ? 48'sh7FFF_FFFF_FFFF : 48'(mag);
                end
            end
            OP_KSIN: t1_next = 36'(mul_p >>> 28);
            OP_INV: begin
                if (!w[36]) z_next = 32'({2'b00, w[29:0]});
                else        z_next = -32'({2'b00, wn[29:0]});
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        z_reg <= z_next;   om_reg <= om_next;  k_reg <= k_next;
        fail_reg <= fail_next; quad_reg <= quad_next; x_reg <= x_next;
        arg_reg <= arg_next; s_reg <= s_next; t_reg <= t_next; a_reg <= a_next;
        sn_reg <= sn_next; cs_reg <= cs_next; prod_reg <= prod_next;
        ua_reg <= ua_next; ub_reg <= ub_next; neg_reg <= neg_next;
        mh_reg <= mh_next; t1_reg <= t1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (cmd.op == OP_DONE) begin
            ov_reg <= 1'b1;
        end else if (m_axis_tready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_DONE) begin
            dev_reg <= fail_reg ? '1 : dev;
            np_reg  <= fail_reg;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = dev_reg;
    assign m_axis_tuser  = np_reg;

endmodule

// ===== tb/circle_map_multiplier_residual_core_test.sv =====
// Self-checking testbench of circle_map_multiplier_residual_core: directed and random items
// are checked against a built-in fixed-point model of the orbit multiplier.
// Depends on cmmr_pkg and the core RTL.
`timescale 1ns / 1ps

module circle_map_multiplier_residual_core_test;
    import cmmr_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int MAX_LATENCY = 3 + 22 * MAX_PERIOD + 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 500;

    localparam longint unsigned QS_C1 = 1686629713;
    localparam longint unsigned QS_C3 = 693598668;
    localparam longint unsigned QS_C5 = 85569305;
    localparam longint unsigned QS_C7 = 5026995;
    localparam longint unsigned QS_C9 = 172272;
    localparam longint unsigned QS_C11 = 3864;
    localparam longint unsigned QS_C13 = 61;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint Q24_ONE = 64'sd16777216;
    localparam longint TURN_INV = 64'sd683565276;
    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint unsigned SAT_NEG_MAG = 64'd140737488355328;

    typedef struct {
        logic [47:0] deviation;
        logic        not_periodic;
    } orbit_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [47:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;  // start_point, omega, k_gain, pp_value
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;  // deviation
    logic         m_axis_tuser;  // not_periodic

    logic [4:0]         period_reg;
    logic [31:0]        thr_reg;
    logic signed [47:0] target_reg;

    orbit_result_t expected_q[$];
    int  errors;
    int  items_sent;
    int  results_seen;
    int  idle_cycles;
    int  hold_left;
    bit  sender_steady;
    bit  receiver_steady;

    circle_map_multiplier_residual_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // sin(pi/2 * x), Q30
    function automatic longint quarter_sine(longint unsigned x);
        longint unsigned s, t;
        s = (x * x) >> 30;
        t = QS_C13;
        t = QS_C11 - ((s * t) >> 30);
        t = QS_C9 - ((s * t) >> 30);
        t = QS_C7 - ((s * t) >> 30);
        t = QS_C5 - ((s * t) >> 30);
        t = QS_C3 - ((s * t) >> 30);
        t = QS_C1 - ((s * t) >> 30);
        return longint'((x * t) >> 30);
    endfunction

    function automatic void turn_sincos(input longint z, output longint sn, output longint cs);
        longint unsigned u, x;
        longint a, b;
        u = longint'(z) & 64'h3FFF_FFFF;
        x = (u & 64'h0FFF_FFFF) << 2;
        a = quarter_sine(x);
        b = quarter_sine(64'(Q30_ONE) - x);
        case (u >> 28)
            0: begin sn = a; cs = b; end
            1: begin sn = b; cs = -a; end
            2: begin sn = -a; cs = -b; end
            default: begin sn = -b; cs = a; end
        endcase
    endfunction

    function automatic longint sat_mul(longint a, longint b);
        bit neg;
        longint unsigned ua, ub, mag;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        mag = (ua >> 24) * ub + (((ua & 64'hFF_FFFF) * ub) >> 24);
        if (neg) begin
            if (mag >= SAT_NEG_MAG) return -SAT_HI - 1;
            return -longint'(mag);
        end
        if (mag > longint'(SAT_HI)) return SAT_HI;
        return longint'(mag);
    endfunction

    function automatic orbit_result_t predict_deviation(logic [31:0] z0, logic [31:0] om,
                                                        logic [31:0] kg, logic [31:0] pp);
        orbit_result_t r;
        longint z, o, k, prod, sn, cs, t, w, d;
        int p;
        z = longint'(signed'(z0));
        o = longint'(signed'(om));
        k = longint'(signed'(kg));
        if (pp >= thr_reg) begin
            r.deviation = '1;
            r.not_periodic = 1'b1;
            return r;
        end
        p = period_reg;
        if (p < 1) p = 1;
        if (p > MAX_PERIOD) p = MAX_PERIOD;
        prod = Q24_ONE;
        for (int i = 0; i < p; i++) begin
            turn_sincos(z, sn, cs);
            prod = sat_mul(prod, Q24_ONE - ((k * cs) >>> 34));
            if (i + 1 < p) begin
                t = (k * sn) >>> 28;
                t = (t * TURN_INV) >>> 32;
                w = z + o - t;
                z = (w >= 0) ? (w & (Q30_ONE - 1)) : -((-w) & (Q30_ONE - 1));
            end
        end
        d = prod - longint'(target_reg);
        if (d < 0) d = -d;
        r.deviation = d[47:0];
        r.not_periodic = 1'b0;
        return r;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [31:0] z0, logic [31:0] om, logic [31:0] kg,
                             logic [31:0] pp);
        int gap;
        gap = sender_steady ? 0 : rand_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pp, kg, om, z0};
        do @(posedge aclk); while (!s_axis_tready);
        expected_q.insert(expected_q.size(), predict_deviation(z0, om, kg, pp));
        items_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (MAX_LATENCY) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [47:0] val);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PERIOD: period_reg = val[4:0];
            REG_THR:    thr_reg = val[31:0];
            REG_TARGET: target_reg = val;
            default: ;
        endcase
    endtask

    task automatic send_random_item(int accept_pct);
        logic [31:0] kg, pp;
        kg = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1 << 29) - (1 << 28);
        if (thr_reg != 0 && $urandom_range(0, 99) < accept_pct)
            pp = $urandom % thr_reg;
        else
            pp = $urandom;
        send_item($urandom, $urandom, kg, pp);
    endtask

    task automatic test_reset_defaults();
        send_item(32'h0, 32'h0, 32'h0, 32'h0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_item(32'hFFFF_FFFF, 32'h4000_0000, 32'h1000_0000, 32'd10736);
        send_item(32'h1000_0000, 32'hC000_0000, 32'hF000_0000, 32'd10737);
        send_item(32'h2000_0000, 32'h0, 32'h1000_0000, 32'hFFFF_FFFF);
        send_item(32'h3000_0000, 32'h1234_5678, 32'hEDCB_A988, 32'd5);
    endtask

    task automatic test_period_clamp();
        logic [4:0] periods[5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
        foreach (periods[i]) begin
            cfg_write(REG_PERIOD, 48'(periods[i]));
            send_item($urandom, $urandom, $urandom, 32'd0);
            send_item(32'h4000_0000, 32'h2000_0000, 32'h7FFF_FFFF, 32'd1);
        end
        cfg_write(REG_PERIOD, 48'd2);
    endtask

    task automatic test_threshold_and_target();
        cfg_write(REG_THR, 48'd0);
        send_item($urandom, $urandom, $urandom, 32'd0);
        cfg_write(REG_THR, 48'hFFFF_FFFF);
        send_item($urandom, $urandom, $urandom, 32'hFFFF_FFFE);
        send_item($urandom, $urandom, $urandom, 32'hFFFF_FFFF);
        cfg_write(REG_TARGET, 48'h7FFF_FFFF_FFFF);
        send_item(32'h0, 32'h0, 32'h7FFF_FFFF, 32'd0);
        send_item(32'h2000_0000, 32'h0, 32'h8000_0000, 32'd0);
        cfg_write(REG_TARGET, 48'h8000_0000_0000);
        send_item(32'h0, 32'h0, 32'h7FFF_FFFF, 32'd0);
        send_item(32'h2000_0000, 32'h0, 32'h8000_0000, 32'd0);
        cfg_write(REG_TARGET, 48'h0000_0100_0000);
        send_item(32'h0, 32'h0, 32'h0, 32'd0);
        // unknown register index must leave the settings alone
        cfg_write(REG_UNUSED, 48'h0000_0000_0003);
        send_item($urandom, $urandom, $urandom, 32'd7);
    endtask

    task automatic test_random_phases();
        int r;
        for (int ph = 0; ph < 12; ph++) begin
            r = $urandom_range(0, 99);
            if (r < 70) cfg_write(REG_PERIOD, 48'($urandom_range(1, 3)));
            else if (r < 85) cfg_write(REG_PERIOD, 48'($urandom_range(4, 8)));
            else cfg_write(REG_PERIOD, 48'($urandom_range(0, 1) ? 16 : $urandom_range(0, 31)));
            cfg_write(REG_THR, (ph % 3 == 0) ? 48'($urandom) : 48'($urandom_range(1, 1 << 20)));
            r = $urandom_range(0, 2);
            cfg_write(REG_TARGET, (r == 0) ? 48'hFFFF_FF00_0000 :
                                  (r == 1) ? 48'h0000_0100_0000 : 48'({$urandom, $urandom}));
            sender_steady = (ph % 4 == 1);
            receiver_steady = (ph % 4 == 2);
            for (int i = 0; i < 100; i++) send_random_item(85);
            sender_steady = 1'b0;
            receiver_steady = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        cfg_write(REG_PERIOD, 48'd1);
        cfg_write(REG_THR, 48'hFFFF_FFFF);
        hold_left = HOLD_CYCLES;
        sender_steady = 1'b1;
        for (int i = 0; i < 10; i++) send_random_item(100);
        sender_steady = 1'b0;
        drain();
        for (int i = 0; i < 10; i++) send_random_item(90);
    endtask

    // receiver ready
    initial begin
        int gap;
        gap = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_axis_tready <= 1'b0;
            end else begin
                gap = receiver_steady ? 0 : rand_gap();
                m_axis_tready <= (gap == 0);
                if (gap > 0) gap--;
            end
        end
    end

    // result checker
    initial begin
        orbit_result_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result deviation=%h not_periodic=%b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_axis_tdata !== exp_r.deviation) begin
                        $error("deviation: expected %h, actual %h", exp_r.deviation,
                               m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== exp_r.not_periodic) begin
                        $error("not_periodic: expected %b, actual %b", exp_r.not_periodic,
                               m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("[circle_map_multiplier_residual_core] ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_left = 0;
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
        period_reg = PERIOD_RST;
        thr_reg = THR_RST;
        target_reg = TARGET_RST;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_PERIOD;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_period_clamp();
        test_threshold_and_target();
        test_backpressure();
        test_random_phases();
        drain();

        $display("covered %0d items, %0d results: periods 0..31, threshold and target extremes,",
                 items_sent, results_seen);
        $display("random orbits under random stalls and a long output hold-off");
        if (errors == 0)
            $display("[circle_map_multiplier_residual_core] OK");
        else
            $display("[circle_map_multiplier_residual_core] ERROR");
        $finish;
    end

endmodule
